@@ hdl/tpe_pkg.sv @@
// Package for the TCP payload extractor.
// Holds the item type passed between front, queue and back, and the header constants.
// No dependencies.
`default_nettype none

package tpe_pkg;

   // One payload item as it travels from the parser to the output register
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_last;
   } item_type;

   // A packet always spans at least this many bytes, even with a short length
   localparam logic [15:0] MIN_PACKET_BYTES = 16'd20;

   // The data offset nibble sits this many bytes past the end of the IP header
   localparam logic [6:0] TCP_OFFSET_BASE = 7'd12;

endpackage : tpe_pkg

`default_nettype wire

@@ hdl/tpe_front.sv @@
// Front end of the TCP payload extractor: per-packet parse state and payload classification.
// Depends on tpe_pkg.
`default_nettype none

module tpe_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        req_in_byte,
   input  wire logic              req_stream_start,
   output logic                   item_valid,
   output tpe_pkg::item_type      item
);
   import tpe_pkg::*;

   logic [15:0] position_ff, position_in;
   logic [15:0] length_ff, length_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [3:0]  doff_ff, doff_in;
   logic        seen_ff, seen_in;

   logic [15:0] pos_cur;
   logic [15:0] len_cur;
   logic [3:0]  ihl_cur;
   logic [3:0]  doff_cur;
   logic        seen_cur;
   logic [6:0]  offset_pos;
   logic        take_offset;
   logic [6:0]  header_len;
   logic [16:0] pos_next;
   logic [15:0] end_len;
   logic        packet_done;

   always_comb begin
      // A start flag drops all parse state before this byte is looked at
      pos_cur  = req_stream_start ? 16'd0 : position_ff;
      len_cur  = req_stream_start ? 16'd0 : length_ff;
      ihl_cur  = req_stream_start ? 4'd0  : ihl_ff;
      doff_cur = req_stream_start ? 4'd0  : doff_ff;
      seen_cur = req_stream_start ? 1'b0  : seen_ff;

      ihl_in    = ihl_cur;
      length_in = len_cur;
      if (pos_cur == 16'd0) begin
         ihl_in = req_in_byte[3:0];
      end else if (pos_cur == 16'd2) begin
         length_in = {req_in_byte, 8'h00};
      end else if (pos_cur == 16'd3) begin
         length_in = {len_cur[15:8], req_in_byte};
      end

      offset_pos  = {1'b0, ihl_in, 2'b00} + TCP_OFFSET_BASE;
      take_offset = !seen_cur && (pos_cur == {9'd0, offset_pos});
      doff_in     = take_offset ? req_in_byte[7:4] : doff_cur;
      seen_in     = seen_cur | take_offset;

      header_len = {1'b0, ihl_in, 2'b00} + {1'b0, doff_in, 2'b00};
      pos_next   = {1'b0, pos_cur} + 17'd1;

      item_valid = accept && seen_in && (pos_cur >= {9'd0, header_len})
                   && (pos_cur < length_in);
      item.payload_byte = req_in_byte;
      item.payload_last = (pos_next == {1'b0, length_in});

      end_len     = (length_in > MIN_PACKET_BYTES) ? length_in : MIN_PACKET_BYTES;
      packet_done = (pos_next >= {1'b0, end_len});
      position_in = pos_next[15:0];
      if (packet_done) begin
         position_in = 16'd0;
         length_in   = 16'd0;
         ihl_in      = 4'd0;
         doff_in     = 4'd0;
         seen_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= 16'd0;
         length_ff   <= 16'd0;
         ihl_ff      <= 4'd0;
         doff_ff     <= 4'd0;
         seen_ff     <= 1'b0;
      end else if (accept) begin
         position_ff <= position_in;
         length_ff   <= length_in;
         ihl_ff      <= ihl_in;
         doff_ff     <= doff_in;
         seen_ff     <= seen_in;
      end
   end

endmodule : tpe_front

`default_nettype wire

@@ hdl/tpe_queue.sv @@
// Short queue between the parser front end and the output stage.
// Depends on tpe_pkg.
`default_nettype none

module tpe_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire tpe_pkg::item_type wr_item,
   input  wire logic              rd_en,
   output tpe_pkg::item_type      rd_item,
   output logic                   is_full,
   output logic                   is_empty
);
   import tpe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   item_type         slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_ptr_ff] <= wr_item;
      end
   end

   assign rd_item  = slots_ff[rd_ptr_ff];
   assign is_full  = (count_ff == FULL_COUNT);
   assign is_empty = (count_ff == '0);

endmodule : tpe_queue

`default_nettype wire

@@ hdl/tpe_back.sv @@
// Output stage of the TCP payload extractor: holds the oldest item for the consumer.
// Depends on tpe_pkg.
`default_nettype none

module tpe_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              queue_empty,
   input  wire tpe_pkg::item_type queue_item,
   output logic                   queue_pop,
   input  wire logic              pop,
   output logic                   empty,
   output logic [7:0]             rsp_payload_byte,
   output logic                   rsp_payload_last
);
   import tpe_pkg::*;

   logic     valid_ff, valid_in;
   item_type hold_ff;

   always_comb begin
      // Refill when the register is free or being drained this cycle
      queue_pop = !queue_empty && (!valid_ff || pop);
      valid_in  = queue_pop || (valid_ff && !pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         hold_ff <= queue_item;
      end
   end

   assign empty            = !valid_ff;
   assign rsp_payload_byte = hold_ff.payload_byte;
   assign rsp_payload_last = hold_ff.payload_last;

endmodule : tpe_back

`default_nettype wire

@@ hdl/tcp_payload_extractor_top.sv @@
// Top level of the TCP payload extractor: front end, item queue and output stage.
// Depends on tpe_pkg, tpe_front, tpe_queue and tpe_back.
`default_nettype none

// Extracts TCP payload bytes from a stream of back-to-back IPv4/TCP packets, one
// input byte per cycle sustained while full stays low. Each byte pushed is
// classified in the cycle it is accepted: byte 0 gives the IP header length (low
// nibble times 4), bytes 2 and 3 the big-endian total length, and the byte at IP
// header length plus 12 the TCP data offset. Bytes at or past both the combined
// header length and the data offset byte, and before the total length, come out
// as payload items, in stream order, with payload_last set on the byte at total
// length minus 1. A packet ends at its total length but never before byte 20, so
// a zero or short length cannot stall parsing; such packets, and packets whose
// headers reach past their length, give no payload. Setting req_stream_start
// restarts parsing with that byte as byte 0. Both sides look like a queue:
// push/full in, empty/pop out. A pushed payload byte passes through the queue,
// then the output register, before it shows on the result ports; the queue of
// QUEUE_DEPTH items plus the output register absorb consumer stalls, and full rises only when all of them hold items.
module tcp_payload_extractor_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_stream_start,
   output logic            empty,
   input  wire logic       pop,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_payload_last
);
   import tpe_pkg::*;

   logic     accept;
   logic     front_valid;
   item_type front_item;
   item_type queue_item;
   logic     queue_full;
   logic     queue_empty;
   logic     queue_pop;

   // Take a byte only when the queue has room for its possible payload item
   assign full   = queue_full;
   assign accept = push && !queue_full;

   tpe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_in_byte      (req_in_byte),
      .req_stream_start (req_stream_start),
      .item_valid       (front_valid),
      .item             (front_item)
   );

   // Decouple the parser from consumer stalls
   tpe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (front_valid),
      .wr_item  (front_item),
      .rd_en    (queue_pop),
      .rd_item  (queue_item),
      .is_full  (queue_full),
      .is_empty (queue_empty)
   );

   // Hold the oldest item on the result ports until popped
   tpe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .queue_item       (queue_item),
      .queue_pop        (queue_pop),
      .pop              (pop),
      .empty            (empty),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_last (rsp_payload_last)
   );

endmodule : tcp_payload_extractor_top

`default_nettype wire

@@ tb/payload_checker.sv @@
// Checker for the TCP payload extractor: follows packet parsing on every accepted byte,
// queues the payload items each byte should give and compares them as they pop out.
// Depends on tpe_pkg for the item type and the header constants.
module payload_checker
   import tpe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_stream_start,
   input  logic       empty,
   input  logic       pop,
   input  logic [7:0] rsp_payload_byte,
   input  logic       rsp_payload_last,
   output int         mismatch_count,
   output int         payload_pending
);

   logic [15:0] byte_position;
   logic [15:0] packet_length;
   logic [3:0]  ip_header_words;
   logic [3:0]  tcp_offset_words;
   logic        tcp_offset_seen;
   item_type    expected_payload[$];
   int          mismatch_total;

   task automatic restart_packet();
      byte_position    = '0;
      packet_length    = '0;
      ip_header_words  = '0;
      tcp_offset_words = '0;
      tcp_offset_seen  = 1'b0;
   endtask

   initial begin
      mismatch_total  = 0;
      mismatch_count  = 0;
      payload_pending = 0;
   end

   always @(posedge clock) begin : track
      int unsigned pos;
      int unsigned offset_pos;
      int unsigned header_len;
      int unsigned packet_end;
      item_type    got;
      item_type    want;
      if (reset) begin
         restart_packet();
         expected_payload.delete();
      end else begin
         // results never leave in the cycle their byte is taken, so check first
         if (pop && !empty) begin
            got.payload_byte = rsp_payload_byte;
            got.payload_last = rsp_payload_last;
            if (expected_payload.size() == 0) begin
               if (mismatch_total < 10)
                  $display("%0t: payload item with nothing expected: byte %h last %b",
                           $time, got.payload_byte, got.payload_last);
               mismatch_total++;
            end else begin
               want = expected_payload.pop_front();
               if (got.payload_byte !== want.payload_byte ||
                   got.payload_last !== want.payload_last) begin
                  if (mismatch_total < 10)
                     $display("%0t: payload mismatch: byte exp %h got %h, last exp %b got %b",
                              $time, want.payload_byte, got.payload_byte,
                              want.payload_last, got.payload_last);
                  mismatch_total++;
               end
            end
         end
         if (push && !full) begin
            if (req_stream_start)
               restart_packet();
            pos = 32'(byte_position);
            if (pos == 0)
               ip_header_words = req_in_byte[3:0];
            else if (pos == 2)
               packet_length = {req_in_byte, 8'h00};
            else if (pos == 3)
               packet_length[7:0] = req_in_byte;
            offset_pos = ip_header_words * 4 + TCP_OFFSET_BASE;
            if (!tcp_offset_seen && pos == offset_pos) begin
               tcp_offset_words = req_in_byte[7:4];
               tcp_offset_seen  = 1'b1;
            end
            // bytes ahead of the data offset byte never qualify
            if (tcp_offset_seen) begin
               header_len = ip_header_words * 4 + tcp_offset_words * 4;
               if (pos >= header_len && pos < packet_length) begin
                  want.payload_byte = req_in_byte;
                  want.payload_last = (pos + 1 == packet_length);
                  expected_payload.push_back(want);
               end
            end
            packet_end = 32'((packet_length > MIN_PACKET_BYTES) ? packet_length
                                                                 : MIN_PACKET_BYTES);
            if (pos + 1 >= packet_end)
               restart_packet();
            else
               byte_position = 16'(pos + 1);
         end
      end
      mismatch_count  <= mismatch_total;
      payload_pending <= expected_payload.size();
   end

endmodule

@@ tb/testbench.sv @@
// Top of the TCP payload extractor testbench: clock, reset, byte stimulus and verdict.
// Depends on tpe_pkg, tcp_payload_extractor_top and payload_checker.
module testbench;
   import tpe_pkg::*;

   // quiet cycles with nothing accepted on either side before giving up
   localparam int WATCHDOG_LIMIT  = 2000;
   // cycles to keep watching after the last expected item has left
   localparam int DRAIN_CYCLES    = 16;
   // least number of random bytes pushed in each idling phase
   localparam int BYTES_PER_PHASE = 230;
   localparam int PHASE_COUNT     = 4;

   logic       clock;
   logic       reset;
   logic       push;
   logic       full;
   logic [7:0] req_in_byte;
   logic       req_stream_start;
   logic       empty;
   logic       pop;
   logic [7:0] rsp_payload_byte;
   logic       rsp_payload_last;

   int mismatches;
   int payload_pending;
   int bytes_sent;
   int quiet_cycles = 0;
   int sender_idle_pct;
   int receiver_stall_pct;
   // set when the parser may be mid-packet, so the next packet must restart it
   bit resync_needed;

   // idling per phase: none, sender only, receiver only, both lightly
   int sender_idle_table[PHASE_COUNT]    = '{0, 74, 0, 6};
   int receiver_stall_table[PHASE_COUNT] = '{0, 0, 74, 6};

   tcp_payload_extractor_top dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_in_byte      (req_in_byte),
      .req_stream_start (req_stream_start),
      .empty            (empty),
      .pop              (pop),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_last (rsp_payload_last)
   );

   payload_checker payload_watch (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_in_byte      (req_in_byte),
      .req_stream_start (req_stream_start),
      .empty            (empty),
      .pop              (pop),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_last (rsp_payload_last),
      .mismatch_count   (mismatches),
      .payload_pending  (payload_pending)
   );

   always #5 clock = ~clock;

   // Stall the receiver at random; the rate follows the current phase.
   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Count cycles in which neither side moves an item; end the run when stuck.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no item accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("[tcp_payload_extractor_top] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Push one byte. Enter and leave at a falling edge; idle at random first,
   // then hold the byte until a rising edge finds full low.
   task automatic send_byte(input logic [7:0] value, input logic restart);
      while ($urandom_range(99) < sender_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push             <= 1'b1;
      req_in_byte      <= value;
      req_stream_start <= restart;
      @(posedge clock);
      while (full)
         @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // Push one packet of count bytes with the given header fields; every other
   // byte is random. A count short of the packet end leaves a truncated packet.
   task automatic send_packet(input logic [3:0] ihl, input logic [3:0] doff,
                              input logic [15:0] length, input int count,
                              input logic restart);
      int         offset_pos;
      logic [7:0] value;
      offset_pos = ihl * 4 + TCP_OFFSET_BASE;
      for (int i = 0; i < count; i++) begin
         value = 8'($urandom);
         case (i)
            0: value = {4'h4, ihl};
            2: value = length[15:8];
            3: value = length[7:0];
            default: begin
               if (i == offset_pos)
                  value = {doff, value[3:0]};
            end
         endcase
         send_byte(value, restart && i == 0);
      end
   endtask

   // Pick one stretch of traffic: mostly well-formed packets with random
   // content, the rest truncated packets, odd header fields and raw noise.
   task automatic send_random_packet();
      int   pick;
      int   ihl;
      int   doff;
      int   length;
      int   count;
      logic restart;
      pick = $urandom_range(99);
      if (pick >= 94) begin
         // raw noise with a stray restart now and then
         count = $urandom_range(1, 24);
         for (int i = 0; i < count; i++)
            send_byte(8'($urandom), $urandom_range(9) == 0);
         resync_needed = 1'b1;
      end else begin
         ihl    = $urandom_range(1) ? 5 : $urandom_range(5, 15);
         doff   = $urandom_range(1) ? 5 : $urandom_range(5, 15);
         length = ihl * 4 + doff * 4 + ($urandom_range(3) == 0 ? 0 : $urandom_range(1, 24));
         count  = length;
         if (pick < 12) begin
            // cut short; sometimes with a length from the whole 16-bit range
            if ($urandom_range(4) == 0)
               length = $urandom_range(65535);
            count = $urandom_range(1, 60);
         end else if (pick < 24) begin
            // any header fields: short lengths, tiny offsets, zero header length
            ihl    = $urandom_range(15);
            doff   = $urandom_range(15);
            length = $urandom_range(80);
            count  = (length > MIN_PACKET_BYTES) ? length : MIN_PACKET_BYTES;
         end
         restart = resync_needed || $urandom_range(1);
         send_packet(4'(ihl), 4'(doff), 16'(length), count, restart);
         resync_needed = (pick < 12);
      end
   endtask

   initial begin
      int phase_goal;
      clock              = 1'b0;
      reset              = 1'b1;
      push               = 1'b0;
      pop                = 1'b0;
      req_in_byte        = '0;
      req_stream_start   = 1'b0;
      bytes_sent         = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      resync_needed      = 1'b1;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed packets, no idling.
      // length 24 ends before the data offset byte: no payload
      send_packet(4'd5, 4'd5, 16'd24, 24, 1'b1);
      // zero length, back to back without a restart: ends at byte 20, no payload
      send_packet(4'd5, 4'd5, 16'd0, 20, 1'b0);
      // headers reach past the length: no payload
      send_packet(4'd5, 4'd8, 16'd36, 36, 1'b0);
      // data offset byte lies past the length: no payload
      send_packet(4'd15, 4'd5, 16'd40, 40, 1'b0);
      // zero data offset: payload only from the offset byte onward
      send_packet(4'd5, 4'd0, 16'd40, 40, 1'b0);
      // zero header length: data offset taken from byte 12
      send_packet(4'd0, 4'd5, 16'd30, 30, 1'b0);
      // largest length, cut short, then a restart mid-packet
      send_packet(4'd5, 4'd5, 16'hffff, 50, 1'b0);
      send_packet(4'd15, 4'd15, 16'd121, 121, 1'b1);
      resync_needed = 1'b0;

      // Random traffic through each idling phase.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         sender_idle_pct    = sender_idle_table[phase];
         receiver_stall_pct = receiver_stall_table[phase];
         phase_goal         = bytes_sent + BYTES_PER_PHASE;
         while (bytes_sent < phase_goal)
            send_random_packet();
      end
      push <= 1'b0;

      // Drain every expected item, then watch a while for strays.
      while (payload_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && payload_pending == 0)
         $display("[tcp_payload_extractor_top] OK");
      else
         $display("[tcp_payload_extractor_top] ERROR");
      $finish;
   end

endmodule
